/* design/brre_pkg.sv */
// Shared types and constants for the binary row run extractor.
// Used by brre_scan and binary_row_run_extractor_core; no dependencies.
package brre_pkg;

	// Fixed field widths
	localparam int CFG_W      = 13;  // configuration register width
	localparam int COL_W      = 13;  // column values, widths up to 8191
	localparam int LINE_OUT_W = 12;
	localparam int START_W    = 12;
	localparam int END_W      = 13;

	// Register reset values
	localparam int ROW_WIDTH_RESET = 1024;
	localparam int ROW_COUNT_RESET = 1024;

	// Most runs one byte can produce: four closures plus the row end
	localparam int RES_N = 5;
	localparam int CNT_W = $clog2(RES_N + 1);

	typedef enum logic [0:0] {
		REG_ROW_WIDTH = 1'b0,
		REG_ROW_COUNT = 1'b1
	} brre_reg_t;

	typedef struct packed {
		logic [COL_W-1:0] start;
		logic [COL_W-1:0] stop;
	} brre_run_t;

	typedef struct packed {
		logic [CNT_W-1:0]            count;
		brre_run_t [RES_N-1:0]       runs;
		logic                        open;
		logic [COL_W-1:0]            open_start;
	} brre_scan_t;

endpackage

/* design/binary_row_run_extractor_core.sv */
// Top level of the binary row run extractor: row state, burst output stage.
// Depends on brre_pkg and brre_scan.
//
// Usage:
//   Input channel (in_valid/in_ready/pixel_byte) takes one bitmap byte per
//   item, MSB is the leftmost pixel, 0 is dark. Rows are padded to whole
//   ROW_ALIGN_BITS words; padding bytes only advance the byte position.
//   Output channel (out_valid/out_ready) gives one dark run per item as
//   line_index, run_start, run_end (exclusive); last_of_item flags the
//   final run caused by a byte. Bytes that close no run produce nothing.
//   Configuration: cfg_we/cfg_index/cfg_wdata write row_width_pixels (0)
//   or row_count (1); write only while the block is idle.
//   Path: an accepted byte is registered in the input stage, scanned and
//   its runs loaded into the burst register. Throughput: one byte per cycle;
//   the burst register drains one run per cycle while out_ready is high, and
//   the input stage waits only when a new byte has runs to hand over.
//   Reset: registers go to width 1024, row count 1024, position, line and
//   open run cleared; no clearing pass, the block is ready after reset.
//   Receiver stall: the burst register holds its run; the input stage
//   keeps taking bytes until one that yields runs finds the burst full.
module binary_row_run_extractor_core #(
	parameter int MAX_WIDTH      = 4096,
	parameter int MAX_ROWS       = 4096,
	parameter int ROW_ALIGN_BITS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  brre_pkg::brre_reg_t               cfg_index,
	input  logic [brre_pkg::CFG_W-1:0]        cfg_wdata,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [7:0]                        pixel_byte,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [brre_pkg::LINE_OUT_W-1:0]   line_index,
	output logic [brre_pkg::START_W-1:0]      run_start,
	output logic [brre_pkg::END_W-1:0]        run_end,
	output logic                              last_of_item
);
	import brre_pkg::*;

	// Width and row caps: register values never exceed the CFG_W range
	localparam int CFG_MAX     = 2**CFG_W - 1;
	localparam int COL_CAP     = (MAX_WIDTH < CFG_MAX) ? MAX_WIDTH : CFG_MAX;
	localparam int ROWS_CAP    = (MAX_ROWS < CFG_MAX) ? MAX_ROWS : CFG_MAX;
	localparam int W_RESET     = (ROW_WIDTH_RESET < COL_CAP) ? ROW_WIDTH_RESET : COL_CAP;
	localparam int R_RESET     = (ROW_COUNT_RESET < ROWS_CAP) ? ROW_COUNT_RESET : ROWS_CAP;
	localparam int ALIGN_BYTES = ROW_ALIGN_BITS / 8;

	// Row length in words: ceil(width / ROW_ALIGN_BITS) by reciprocal,
	// exact for every numerator below 2**NUM_W
	localparam int NUM_W    = COL_W + 1;
	localparam int RECIP_SH = NUM_W + $clog2(ROW_ALIGN_BITS) + 1;
	localparam int RECIP    = (2**RECIP_SH + ROW_ALIGN_BITS - 1) / ROW_ALIGN_BITS;
	localparam int PROD_W   = NUM_W + RECIP_SH + 1;
	localparam int Q_RESET  = (W_RESET + ROW_ALIGN_BITS - 1) / ROW_ALIGN_BITS;

	localparam int MAX_RB   = ((COL_CAP + ROW_ALIGN_BITS - 1) / ROW_ALIGN_BITS) * ALIGN_BYTES;
	localparam int BP_W     = $clog2(MAX_RB + 1);
	localparam int RB_RESET = Q_RESET * ALIGN_BYTES;
	localparam int CMP_W    = (BP_W + 3 > COL_W + 1) ? BP_W + 3 : COL_W + 1;

	localparam int ROWS_W   = $clog2(ROWS_CAP + 1);
	localparam int LC_W     = (ROWS_CAP > 1) ? $clog2(ROWS_CAP) : 1;

	// Configuration state
	logic [COL_W-1:0]  width_q;
	logic [ROWS_W-1:0] rows_q;
	logic [BP_W-1:0]   row_bytes_q;

	logic [COL_W-1:0]  width_clamp;
	logic [NUM_W-1:0]  width_num;
	logic [PROD_W-1:0] width_prod;
	logic [ROWS_W-1:0] rows_clamp;

	// Row state
	logic [BP_W-1:0]   bp_q;
	logic [LC_W-1:0]   line_q;
	logic              run_open_q;
	logic [COL_W-1:0]  open_start_q;

	// Input stage
	logic              valid_s1;
	logic [7:0]        pixel_s1;

	// Burst stage: the runs of one byte, drained one per cycle while out_ready is high
	logic                  valid_s2;
	brre_run_t [RES_N-1:0] runs_s2;
	logic [CNT_W-1:0]      cnt_s2;
	logic [CNT_W-1:0]      idx_s2;
	logic [LC_W-1:0]       line_s2;

	logic [BP_W+2:0]   base_full;
	logic              in_row;
	brre_scan_t        scan;
	logic              last_run;
	logic              out_fire;
	logic              burst_free;
	logic              adv_s1;
	logic              load_s2;
	logic [BP_W-1:0]   bp_inc;
	logic              row_done;
	logic [ROWS_W-1:0] line_inc;

	// Clamp incoming register values to their legal ranges
	always_comb begin
		if (cfg_wdata == '0) begin
			width_clamp = COL_W'(1);
		end else if (32'(cfg_wdata) > 32'(COL_CAP)) begin
			width_clamp = COL_W'(COL_CAP);
		end else begin
			width_clamp = COL_W'(cfg_wdata);
		end
		if (cfg_wdata == '0) begin
			rows_clamp = ROWS_W'(1);
		end else if (32'(cfg_wdata) > 32'(ROWS_CAP)) begin
			rows_clamp = ROWS_W'(ROWS_CAP);
		end else begin
			rows_clamp = ROWS_W'(cfg_wdata);
		end
	end

	assign width_num  = NUM_W'(width_clamp) + NUM_W'(ROW_ALIGN_BITS - 1);
	assign width_prod = PROD_W'(width_num) * PROD_W'(RECIP);

	// Store the clamped width together with the padded row length in bytes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= COL_W'(W_RESET);
			rows_q <= ROWS_W'(R_RESET);
			row_bytes_q <= BP_W'(RB_RESET);
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_ROW_WIDTH: begin
						width_q <= width_clamp;
						row_bytes_q <= BP_W'(32'(width_prod[RECIP_SH +: NUM_W]) *
							32'(ALIGN_BYTES));
					end
					REG_ROW_COUNT: begin
						rows_q <= rows_clamp;
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Scan the byte in the input stage against the current row state
	assign base_full = {bp_q, 3'b000};
	assign in_row = CMP_W'(base_full) < CMP_W'(width_q);

	brre_scan u_scan (
		.pixel      (pixel_s1),
		.in_row     (in_row),
		.base       ((COL_W+1)'(base_full)),
		.width      (width_q),
		.run_open   (run_open_q),
		.open_start (open_start_q),
		.scan       (scan)
	);

	// Handshake: a byte with no runs always advances; one with runs waits
	// for the burst stage to empty or hand over its last run this cycle.
	assign last_run   = idx_s2 == (cnt_s2 - CNT_W'(1));
	assign out_fire   = valid_s2 && out_ready;
	assign burst_free = !valid_s2 || (out_ready && last_run);
	assign adv_s1     = valid_s1 && ((scan.count == '0) || burst_free);
	assign load_s2    = adv_s1 && (scan.count != '0);
	assign in_ready   = !valid_s1 || adv_s1;

	assign bp_inc   = bp_q + BP_W'(1);
	assign row_done = bp_inc >= row_bytes_q;
	assign line_inc = ROWS_W'(line_q) + ROWS_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			pixel_s1 <= pixel_byte;
		end
	end

	// Advance the row position; a row end drops any open run and steps the line
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bp_q <= '0;
			line_q <= '0;
			run_open_q <= 1'b0;
			open_start_q <= '0;
		end else if (adv_s1) begin
			open_start_q <= scan.open_start;
			if (row_done) begin
				bp_q <= '0;
				run_open_q <= 1'b0;
				if (line_inc >= rows_q) begin
					line_q <= '0;
				end else begin
					line_q <= LC_W'(line_inc);
				end
			end else begin
				bp_q <= bp_inc;
				run_open_q <= scan.open;
			end
		end
	end

	// Burst stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			cnt_s2 <= '0;
			idx_s2 <= '0;
		end else if (load_s2) begin
			valid_s2 <= 1'b1;
			cnt_s2 <= scan.count;
			idx_s2 <= '0;
		end else if (out_fire) begin
			if (last_run) begin
				valid_s2 <= 1'b0;
			end else begin
				idx_s2 <= idx_s2 + CNT_W'(1);
			end
		end
	end

	// Burst stage payload: hold the runs and their line until replaced
	always_ff @(posedge clk) begin
		if (load_s2) begin
			runs_s2 <= scan.runs;
			line_s2 <= line_q;
		end
	end

	assign out_valid    = valid_s2;
	assign line_index   = LINE_OUT_W'(line_s2);
	assign run_start    = runs_s2[idx_s2].start[START_W-1:0];
	assign run_end      = END_W'(runs_s2[idx_s2].stop);
	assign last_of_item = last_run;

endmodule

/* design/brre_scan.sv */
// One-byte run scanner: finds the dark runs closed by eight pixels.
// Depends on brre_pkg.
module brre_scan (
	input  logic [7:0]                      pixel,
	input  logic                            in_row,
	input  logic [brre_pkg::COL_W:0]        base,
	input  logic [brre_pkg::COL_W-1:0]      width,
	input  logic                            run_open,
	input  logic [brre_pkg::COL_W-1:0]      open_start,
	output brre_pkg::brre_scan_t            scan
);
	import brre_pkg::*;

	logic [COL_W:0]   col;
	logic [COL_W:0]   width_x;
	logic [COL_W:0]   byte_end;
	logic             open;
	logic [COL_W-1:0] start;
	logic [CNT_W-1:0] n;
	brre_run_t [RES_N-1:0] runs;

	assign width_x  = {1'b0, width};
	assign byte_end = base + (COL_W+1)'(8);

	always_comb begin
		open = run_open;
		start = open_start;
		n = '0;
		runs = '0;
		col = '0;
		if (in_row) begin
			for (int j = 0; j < 8; j++) begin
				col = base + (COL_W+1)'(j);
				if (col < width_x) begin
					if (!pixel[3'(7 - j)]) begin
						if (!open) begin
							open = 1'b1;
							start = col[COL_W-1:0];
						end
					end else if (open) begin
						if (n < CNT_W'(RES_N)) begin
							runs[n] = '{start: start, stop: col[COL_W-1:0]};
							n = n + CNT_W'(1);
						end
						open = 1'b0;
					end
				end
			end
			// close a run that reaches the row width
			if (open && byte_end >= width_x) begin
				if (n < CNT_W'(RES_N)) begin
					runs[n] = '{start: start, stop: width};
					n = n + CNT_W'(1);
				end
				open = 1'b0;
			end
		end
		scan.count = n;
		scan.runs = runs;
		scan.open = open;
		scan.open_start = start;
	end

endmodule
